// ===== design/cpu_8bit_alu_with_flags_top_defines.svh =====
// Assertion macros for the 8-bit ALU with flags.
// Used by the port checker; depends on nothing else.
`ifndef CPU_8BIT_ALU_WITH_FLAGS_TOP_DEFINES_SVH
`define CPU_8BIT_ALU_WITH_FLAGS_TOP_DEFINES_SVH

// Same-cycle implication, disabled while rst_n is low.
`define ALU8F_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while rst_n is low.
`define ALU8F_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/alu8f_pkg.sv =====
// Shared types and constants for the 8-bit ALU with flags.
// No dependencies; used by the core and the top level.
package alu8f_pkg;

    // Operation codes carried on the input channel.
    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_ADC = 4'd1,
        OP_SUB = 4'd2,
        OP_SBC = 4'd3,
        OP_AND = 4'd4,
        OP_XOR = 4'd5,
        OP_OR  = 4'd6,
        OP_CP  = 4'd7,
        OP_INC = 4'd8,
        OP_DEC = 4'd9,
        OP_DAA = 4'd10,
        OP_SCF = 4'd11,
        OP_CCF = 4'd12,
        OP_CPL = 4'd13
    } op_t;

    // Flag register, Z N H C.
    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

    // Everything the ALU produces for one transaction.
    typedef struct packed {
        logic [7:0] value;
        logic       write_back;
        flags_t     flags;
    } alu_res_t;

    // Decimal adjust constants.
    localparam logic [7:0] DAA_LIMIT    = 8'h99;
    localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
    localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
    localparam logic [3:0] NIBBLE_MAX   = 4'hF;
    localparam logic [7:0] BYTE_ONE     = 8'h01;

endpackage

// ===== design/alu8f_core.sv =====
// Combinational datapath of the 8-bit ALU: result, write-back and new flags.
// Depends on alu8f_pkg.
module alu8f_core (
    input  alu8f_pkg::op_t     op,
    input  logic [7:0]         operand_a,
    input  logic [7:0]         operand_b,
    input  alu8f_pkg::flags_t  flags_in,
    output alu8f_pkg::alu_res_t res
);

    logic       add_cin;
    logic       sub_cin;
    logic [8:0] add_sum;
    logic [4:0] add_half;
    logic [8:0] sub_diff;
    logic [4:0] sub_half;
    logic [7:0] inc_val;
    logic [7:0] dec_val;
    logic [7:0] daa_step;
    logic [7:0] daa_val;
    logic       daa_carry;

    // Adder and subtractor share nothing; both are only nine bits wide.
    assign add_cin  = (op == alu8f_pkg::OP_ADC) & flags_in.c;
    assign sub_cin  = (op == alu8f_pkg::OP_SBC) & flags_in.c;
    assign add_sum  = {1'b0, operand_a} + {1'b0, operand_b} + {8'd0, add_cin};
    assign add_half = {1'b0, operand_a[3:0]} + {1'b0, operand_b[3:0]} + {4'd0, add_cin};
    assign sub_diff = {1'b0, operand_a} - {1'b0, operand_b} - {8'd0, sub_cin};
    assign sub_half = {1'b0, operand_a[3:0]} - {1'b0, operand_b[3:0]} - {4'd0, sub_cin};
    assign inc_val  = operand_a + alu8f_pkg::BYTE_ONE;
    assign dec_val  = operand_a - alu8f_pkg::BYTE_ONE;

    // Decimal adjust after an addition or a subtraction, driven by the stored flags.
    always_comb begin
        daa_step  = operand_a;
        daa_val   = operand_a;
        daa_carry = flags_in.c;
        if (!flags_in.n) begin
            if (flags_in.c || (operand_a > alu8f_pkg::DAA_LIMIT)) begin
                daa_step  = operand_a + alu8f_pkg::DAA_HI_ADJ;
                daa_carry = 1'b1;
            end
            daa_val = daa_step;
            if (flags_in.h || (daa_step[3:0] > alu8f_pkg::DAA_LO_LIMIT)) begin
                daa_val = daa_step + alu8f_pkg::DAA_LO_ADJ;
            end
        end else begin
            if (flags_in.c) begin
                daa_step = operand_a - alu8f_pkg::DAA_HI_ADJ;
            end
            daa_val = daa_step;
            if (flags_in.h) begin
                daa_val = daa_step - alu8f_pkg::DAA_LO_ADJ;
            end
        end
    end

    // Operation decode: pick the result and the flag updates.
    always_comb begin
        res.value      = operand_a;
        res.write_back = 1'b1;
        res.flags      = flags_in;
        unique case (op)
            alu8f_pkg::OP_ADD, alu8f_pkg::OP_ADC: begin
                res.value   = add_sum[7:0];
                res.flags.z = (add_sum[7:0] == 8'd0);
                res.flags.n = 1'b0;
                res.flags.h = add_half[4];
                res.flags.c = add_sum[8];
            end
            alu8f_pkg::OP_SUB, alu8f_pkg::OP_SBC, alu8f_pkg::OP_CP: begin
                res.flags.z = (sub_diff[7:0] == 8'd0);
                res.flags.n = 1'b1;
                res.flags.h = sub_half[4];
                res.flags.c = sub_diff[8];
                if (op == alu8f_pkg::OP_CP) begin
                    res.write_back = 1'b0;
                end else begin
                    res.value = sub_diff[7:0];
                end
            end
            alu8f_pkg::OP_AND: begin
                res.value   = operand_a & operand_b;
                res.flags.z = ((operand_a & operand_b) == 8'd0);
                res.flags.n = 1'b0;
                res.flags.h = 1'b1;
                res.flags.c = 1'b0;
            end
            alu8f_pkg::OP_XOR: begin
                res.value   = operand_a ^ operand_b;
                res.flags.z = ((operand_a ^ operand_b) == 8'd0);
                res.flags.n = 1'b0;
                res.flags.h = 1'b0;
                res.flags.c = 1'b0;
            end
            alu8f_pkg::OP_OR: begin
                res.value   = operand_a | operand_b;
                res.flags.z = ((operand_a | operand_b) == 8'd0);
                res.flags.n = 1'b0;
                res.flags.h = 1'b0;
                res.flags.c = 1'b0;
            end
            alu8f_pkg::OP_INC: begin
                res.value   = inc_val;
                res.flags.z = (inc_val == 8'd0);
                res.flags.n = 1'b0;
                res.flags.h = (inc_val[3:0] == 4'd0);
            end
            alu8f_pkg::OP_DEC: begin
                res.value   = dec_val;
                res.flags.z = (dec_val == 8'd0);
                res.flags.n = 1'b1;
                res.flags.h = (dec_val[3:0] == alu8f_pkg::NIBBLE_MAX);
            end
            alu8f_pkg::OP_DAA: begin
                res.value   = daa_val;
                res.flags.z = (daa_val == 8'd0);
                res.flags.h = 1'b0;
                res.flags.c = daa_carry;
            end
            alu8f_pkg::OP_SCF: begin
                res.write_back = 1'b0;
                res.flags.n    = 1'b0;
                res.flags.h    = 1'b0;
                res.flags.c    = 1'b1;
            end
            alu8f_pkg::OP_CCF: begin
                res.write_back = 1'b0;
                res.flags.n    = 1'b0;
                res.flags.h    = 1'b0;
                res.flags.c    = ~flags_in.c;
            end
            alu8f_pkg::OP_CPL: begin
                res.value   = ~operand_a;
                res.flags.n = 1'b1;
                res.flags.h = 1'b1;
            end
            default: begin
                // Unused codes pass the operand through and leave the flags alone.
                res.write_back = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/cpu_8bit_alu_with_flags_top.sv =====
// Top level of the 8-bit ALU with Z/N/H/C flags: input register, flag register,
// output register. Depends on alu8f_pkg and alu8f_core.
//
// Usage:
//   The input channel (s_valid/s_ready) carries one operation per transaction:
//   an opcode and two 8-bit operands. The result channel (m_valid/m_ready)
//   returns the 8-bit value, the write-back bit and the four updated flags.
//   The flags live in a register inside the block; every operation reads the
//   flags left by the operation before it, so DAA, ADC, SBC and CCF see the
//   carry of the preceding transaction.
//   A transaction accepted on the input channel passes the input register and
//   then the output register before it shows up on the result channel.
//   Throughput: one transaction per cycle while m_ready is high; the single
//   compute stage between the two registers sets this, and the flag register
//   is written in that same stage so it is always current.
//   Stall: when m_ready is low the result holds; one more transaction can
//   still be taken into the input register, after which s_ready drops.
//   Reset: aresetn low clears both valid bits and all four flags.
module cpu_8bit_alu_with_flags_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [3:0] s_op,
    input  logic [7:0] s_operand_a,
    input  logic [7:0] s_operand_b,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_result_value,
    output logic       m_write_back,
    output logic       m_zero_flag,
    output logic       m_subtract_flag,
    output logic       m_half_carry_flag,
    output logic       m_carry_flag
);

    logic                in_valid_reg;
    logic                in_valid_next;
    alu8f_pkg::op_t      in_op_reg;
    logic [7:0]          in_a_reg;
    logic [7:0]          in_b_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    alu8f_pkg::alu_res_t out_res_reg;
    alu8f_pkg::flags_t   flags_reg;
    alu8f_pkg::alu_res_t alu_res;
    logic                s_fire;
    logic                advance;

    // Handshake: the compute stage moves forward when the output slot is free or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_valid_next  = s_fire || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_ready);
    end

    // Datapath of one operation.
    alu8f_core u_core (
        .op        (in_op_reg),
        .operand_a (in_a_reg),
        .operand_b (in_b_reg),
        .flags_in  (flags_reg),
        .res       (alu_res)
    );

    // Control state: valid bits and the flag register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                flags_reg <= alu_res.flags;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_op_reg <= alu8f_pkg::op_t'(s_op);
            in_a_reg  <= s_operand_a;
            in_b_reg  <= s_operand_b;
        end
        if (advance) begin
            out_res_reg <= alu_res;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_result_value    = out_res_reg.value;
    assign m_write_back      = out_res_reg.write_back;
    assign m_zero_flag       = out_res_reg.flags.z;
    assign m_subtract_flag   = out_res_reg.flags.n;
    assign m_half_carry_flag = out_res_reg.flags.h;
    assign m_carry_flag      = out_res_reg.flags.c;

endmodule

// ===== design/alu8f_checker.sv =====
// Port-level checker for the 8-bit ALU with flags, bound to the top level.
// Depends on cpu_8bit_alu_with_flags_top_defines.svh.
`include "cpu_8bit_alu_with_flags_top_defines.svh"

module alu8f_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_result_value,
    input logic       m_write_back,
    input logic       m_zero_flag,
    input logic       m_subtract_flag,
    input logic       m_half_carry_flag,
    input logic       m_carry_flag
);

    // Reset empties the result channel.
    `ALU8F_ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_valid, "result valid after reset")

    // A stalled result holds its value, its write-back bit and its Z and C flags.
    `ALU8F_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_result_value) && $stable(m_write_back) && $stable(m_carry_flag) && $stable(m_zero_flag), "stalled result changed")

    // With the receiver kept ready, a transaction passes the input and output registers and then comes out.
    `ALU8F_ASSERT_NEXT(a_latency, aclk, aresetn, s_valid && s_ready && m_ready ##1 m_ready, m_valid, "result missing two cycles after transaction")

    // A draining output never blocks the input side.
    `ALU8F_ASSERT_IMPL(a_no_bubble, aclk, aresetn, m_valid && m_ready, s_ready, "input blocked while result drains")

    // Written-back results with N and H clear always report Z from the value.
    `ALU8F_ASSERT_IMPL(a_zero_flag, aclk, aresetn, m_valid && m_write_back && !m_subtract_flag && !m_half_carry_flag, m_zero_flag == (m_result_value == 8'd0), "zero flag disagrees with result")

endmodule

bind cpu_8bit_alu_with_flags_top alu8f_checker u_alu8f_checker (.*);
